// ----- hw/rtl/counting_hash_multiset_defines.svh -----
// assertion macros for the counting hash multiset
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef COUNTING_HASH_MULTISET_DEFINES_SVH
`define COUNTING_HASH_MULTISET_DEFINES_SVH

// same-cycle implication, off during reset
`define CHM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("counting_hash_multiset: assertion failed");

// next-cycle implication, off during reset
`define CHM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("counting_hash_multiset: assertion failed");

`endif

// ----- hw/rtl/chm_pkg.sv -----
// shared constants, codes and types of the counting hash multiset
// no dependencies
`default_nettype none

package chm_pkg;

    // table geometry
    localparam int MAX_BUCKETS = 64;
    localparam int SLOTS       = 4;
    localparam int BKT_W       = $clog2(MAX_BUCKETS);
    localparam int NBKT_W      = $clog2(MAX_BUCKETS + 1);
    localparam int SLOT_W      = $clog2(SLOTS);

    // field widths
    localparam int KEY_W      = 32;
    localparam int CNT_W      = 32;
    localparam int COEF_W     = 32;
    localparam int HASH_W     = 64;
    localparam int REQ_W      = 2;
    localparam int BC_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // request codes, codes two and three act as a search
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_A       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_B        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd2;

    // count limits
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

    typedef logic [REQ_W-1:0]      t_req_type;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [COEF_W-1:0]     t_coef;
    typedef logic [BKT_W-1:0]      t_bucket;
    typedef logic [NBKT_W-1:0]     t_nbkt;
    typedef logic [BC_W-1:0]       t_bcount;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // one slot of a bucket row
    typedef struct packed {
        t_key   key;
        t_count count;
    } t_slot;

    typedef t_slot [SLOTS-1:0] t_row;

    typedef struct packed {
        logic   found;
        t_count count_after;
        logic   bucket_full;
    } t_rsp;

    // hash unit status
    typedef struct packed {
        logic    done;
        t_bucket bucket;
    } t_hash_res;

    // table command from the top level
    typedef struct packed {
        logic      start;
        t_bucket   bucket;
        t_req_type req_type;
        t_key      key;
    } t_tbl_cmd;

    // table completion
    typedef struct packed {
        logic done;
        t_rsp rsp;
    } t_tbl_res;

endpackage

`default_nettype wire

// ----- hw/rtl/chm_ifs.sv -----
// valid/ready channel interfaces: request, response and register write
// depends on chm_pkg
`default_nettype none

interface chm_req_if;
    import chm_pkg::*;
    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_key      key;
    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface chm_rsp_if;
    import chm_pkg::*;
    logic   valid;
    logic   ready;
    logic   found;
    t_count count_after;
    logic   bucket_full;
    modport source (output valid, output found, output count_after, output bucket_full,
                    input ready);
    modport sink   (input valid, input found, input count_after, input bucket_full,
                    output ready);
endinterface

interface chm_cfg_if;
    import chm_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/chm_hash.sv -----
// bucket hash: (a*key + b) mod n, one product, one add, then a bit-serial remainder
// depends on chm_pkg
`default_nettype none

module chm_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  chm_pkg::t_key      i_key,
    input  chm_pkg::t_coef     i_mult_a,
    input  chm_pkg::t_coef     i_add_b,
    input  chm_pkg::t_nbkt     i_nbkt,
    output chm_pkg::t_hash_res o_res
);
    import chm_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    localparam logic [2:0] HS_IDLE = 3'd0;
    localparam logic [2:0] HS_MUL  = 3'd1;
    localparam logic [2:0] HS_ADD  = 3'd2;
    localparam logic [2:0] HS_DIV  = 3'd3;
    localparam logic [2:0] HS_DONE = 3'd4;

    logic [2:0]        r_state, n_state;
    t_key              r_key, n_key;
    t_nbkt             r_nbkt, n_nbkt;
    logic [HASH_W-1:0] r_acc, n_acc;
    t_bucket           r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic [BKT_W:0]    w_shift;
    logic [BKT_W:0]    w_div;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign w_shift = {r_rem, r_acc[HASH_W-1]};
    assign w_div   = (BKT_W + 1)'(r_nbkt);

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_nbkt  = r_nbkt;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_step  = r_step;
        unique case (r_state)
            HS_IDLE: begin
                if (i_start) begin
                    n_key   = i_key;
                    n_nbkt  = i_nbkt;
                    n_state = HS_MUL;
                end
            end
            HS_MUL: begin
                n_acc   = HASH_W'(i_mult_a) * HASH_W'(r_key);
                n_state = HS_ADD;
            end
            HS_ADD: begin
                n_acc   = r_acc + HASH_W'(i_add_b);
                n_rem   = '0;
                n_step  = '0;
                n_state = HS_DIV;
            end
            HS_DIV: begin
                if (w_shift >= w_div) begin
                    n_rem = BKT_W'(w_shift - w_div);
                end else begin
                    n_rem = BKT_W'(w_shift);
                end
                n_acc  = {r_acc[HASH_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(HASH_W - 1)) begin
                    n_state = HS_DONE;
                end
            end
            HS_DONE: begin
                n_state = HS_IDLE;
            end
            default: begin
                n_state = HS_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_nbkt <= n_nbkt;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_step <= n_step;
    end

    assign o_res.done   = (r_state == HS_DONE);
    assign o_res.bucket = r_rem;

endmodule

`default_nettype wire

// ----- hw/rtl/chm_table.sv -----
// bucket table: row memory of key/count slots plus slot valid flops, read-modify-write
// depends on chm_pkg
`default_nettype none

module chm_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chm_pkg::t_tbl_cmd i_cmd,
    input  logic              i_out_free,
    output chm_pkg::t_tbl_res o_res
);
    import chm_pkg::*;

    localparam logic TS_IDLE = 1'b0;
    localparam logic TS_CMP  = 1'b1;

    logic             r_state, n_state;
    t_bucket          r_bucket;
    t_req_type        r_req;
    t_key             r_key;
    t_row             r_row;
    t_row             mem [MAX_BUCKETS];
    logic [SLOTS-1:0] r_valid [MAX_BUCKETS];

    logic              w_re;
    logic              w_we;
    logic [SLOTS-1:0]  w_vbits;
    logic [SLOTS-1:0]  w_wvalid;
    t_row              w_wrow;
    logic              w_hit;
    logic              w_free;
    logic [SLOT_W-1:0] w_hit_idx;
    logic [SLOT_W-1:0] w_free_idx;
    t_count            w_old;
    t_count            w_new;
    t_rsp              w_rsp;

    assign w_re = (r_state == TS_IDLE) && i_cmd.start;
    assign w_we = (r_state == TS_CMP) && i_out_free;

    // sequencing: read the row, then compare and write back once the result can leave
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: if (i_cmd.start) n_state = TS_CMP;
            TS_CMP:  if (i_out_free) n_state = TS_IDLE;
            default: n_state = TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request held over the access
    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_bucket <= i_cmd.bucket;
            r_req    <= i_cmd.req_type;
            r_key    <= i_cmd.key;
        end
    end

    // row memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_bucket] <= w_wrow;
        end
        if (w_re) begin
            r_row <= mem[i_cmd.bucket];
        end
    end

    // slot valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BUCKETS; b++) begin
                r_valid[b] <= '0;
            end
        end else if (w_we) begin
            r_valid[r_bucket] <= w_wvalid;
        end
    end

    // first matching slot and lowest free slot
    assign w_vbits = r_valid[r_bucket];

    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (w_vbits[s] && (r_row[s].key == r_key) && !w_hit) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(s);
            end
            if (!w_vbits[s] && !w_free) begin
                w_free     = 1'b1;
                w_free_idx = SLOT_W'(s);
            end
        end
    end

    assign w_old = r_row[w_hit_idx].count;

    // modify the row and form the result
    always_comb begin
        w_wrow            = r_row;
        w_wvalid          = w_vbits;
        w_new             = w_old;
        w_rsp.found       = w_hit;
        w_rsp.count_after = w_hit ? w_old : '0;
        w_rsp.bucket_full = 1'b0;
        unique case (r_req)
            REQ_INSERT: begin
                if (w_hit) begin
                    // counts saturate
                    w_new                   = (w_old == COUNT_MAX) ? w_old : w_old + 1'b1;
                    w_wrow[w_hit_idx].count = w_new;
                    w_rsp.count_after       = w_new;
                end else if (w_free) begin
                    w_wrow[w_free_idx].key   = r_key;
                    w_wrow[w_free_idx].count = COUNT_ONE;
                    w_wvalid[w_free_idx]     = 1'b1;
                    w_rsp.count_after        = COUNT_ONE;
                end else begin
                    w_rsp.bucket_full = 1'b1;
                    w_rsp.count_after = '0;
                end
            end
            REQ_DELETE: begin
                if (w_hit) begin
                    if (w_old > COUNT_ONE) begin
                        w_new                   = w_old - 1'b1;
                        w_wrow[w_hit_idx].count = w_new;
                        w_rsp.count_after       = w_new;
                    end else begin
                        // last occurrence frees the slot
                        w_wvalid[w_hit_idx] = 1'b0;
                        w_rsp.count_after   = '0;
                    end
                end
            end
            default: begin
                // search: no change
            end
        endcase
    end

    assign o_res.done = w_we;
    assign o_res.rsp  = w_rsp;

endmodule

`default_nettype wire

// ----- hw/rtl/counting_hash_multiset.sv -----
// top level of the counting hash multiset: registers, sequencing, result register
// depends on chm_pkg, chm_ifs, chm_hash, chm_table and the assertion header
//
//   channel  dir  beat                           handshake
//   i_req    in   req_type, key                  valid/ready
//   o_rsp    out  found, count_after, bucket_full valid/ready
//   i_cfg    in   index, data                    valid/ready, always ready
//
// one request at a time; with the result side draining, each beat passes through
// the idle state taking the beat, the multiply, the add, 64 bit-serial remainder steps,
// the row read and the compare/write.
// the bit-serial remainder by the bucket count is the longest part of that sequence.
// reset clears the slot valid flops at once; no clearing pass is needed.
// a stalled result waits in the output register while the next request is taken.
`default_nettype none

`include "counting_hash_multiset_defines.svh"

module counting_hash_multiset (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp,
    chm_cfg_if.sink   i_cfg
);
    import chm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HASH  = 2'd1;
    localparam logic [1:0] ST_TABLE = 2'd2;

    logic [1:0] r_state, n_state;
    t_req_type  r_req;
    t_key       r_key;
    t_coef      r_mult_a;
    t_coef      r_add_b;
    t_bcount    r_bucket_count;
    logic       r_out_valid;
    t_rsp       r_out;

    logic      w_accept;
    logic      w_out_free;
    t_nbkt     w_nbkt;
    t_hash_res w_hash;
    t_tbl_cmd  w_cmd;
    t_tbl_res  w_tbl;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_a       <= COEF_W'(1);
            r_add_b        <= '0;
            r_bucket_count <= BC_W'(MAX_BUCKETS);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MULT_A:       r_mult_a       <= i_cfg.data;
                CFG_ADD_B:        r_add_b        <= i_cfg.data;
                CFG_BUCKET_COUNT: r_bucket_count <= i_cfg.data[BC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // bucket count in use: zero acts as one, large values clamp
    always_comb begin
        priority if (r_bucket_count == '0) begin
            w_nbkt = NBKT_W'(1);
        end else if (r_bucket_count > BC_W'(MAX_BUCKETS)) begin
            w_nbkt = NBKT_W'(MAX_BUCKETS);
        end else begin
            w_nbkt = NBKT_W'(r_bucket_count);
        end
    end

    // request side
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.req_type;
            r_key <= i_req.key;
        end
    end

    chm_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_key    (i_req.key),
        .i_mult_a (r_mult_a),
        .i_add_b  (r_add_b),
        .i_nbkt   (w_nbkt),
        .o_res    (w_hash)
    );

    assign w_cmd.start    = (r_state == ST_HASH) && w_hash.done;
    assign w_cmd.bucket   = w_hash.bucket;
    assign w_cmd.req_type = r_req;
    assign w_cmd.key      = r_key;

    chm_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_out_free (w_out_free),
        .o_res      (w_tbl)
    );

    // sequencing of one request
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_HASH;
            ST_HASH:  if (w_hash.done) n_state = ST_TABLE;
            ST_TABLE: if (w_tbl.done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tbl.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl.done) begin
            r_out <= w_tbl.rsp;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.count_after = r_out.count_after;
    assign o_rsp.bucket_full = r_out.bucket_full;

    // checks
    `CHM_ASSERT_IMP(a_tbl_needs_room, w_tbl.done, !r_out_valid || o_rsp.ready)
    `CHM_ASSERT_IMP(a_hash_in_seq, w_hash.done, r_state == ST_HASH)
    `CHM_ASSERT_IMP(a_bucket_range, w_hash.done, NBKT_W'(w_hash.bucket) < w_nbkt)
    `CHM_ASSERT_NXT(a_result_shown, w_tbl.done, r_out_valid)
    `CHM_ASSERT_IMP(a_full_clean, r_out_valid && r_out.bucket_full,
                    !r_out.found && (r_out.count_after == '0))

endmodule

`default_nettype wire
